@@ rtl/core/fxlms_pkg.sv @@
// Shared widths, register index codes and reset values for the filtered-x LMS filter.
// No dependencies; the filter top level refers to it by scoped names.
`default_nettype none
package fxlms_pkg;

  // Fixed field and datapath widths
  localparam int SAMPLE_W   = 16;
  localparam int STEP_W     = 16;
  localparam int FLOOR_W    = 16;
  localparam int TAPS_CFG_W = 7;
  localparam int ENERGY_W   = 40;
  localparam int DEN_W      = 41;
  localparam int MU_W       = 32;
  localparam int MUL_A_W    = 48;
  localparam int PROD_W     = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Fractional bits of the weight delta product mu*err*x
  localparam int DELTA_FRAC = 46;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_index_t;

  // Configuration register indexes
  localparam cfg_index_t CFG_MODE  = 3'd0;
  localparam cfg_index_t CFG_STEP  = 3'd1;
  localparam cfg_index_t CFG_FLOOR = 3'd2;
  localparam cfg_index_t CFG_TAPS  = 3'd3;

  // Register reset values
  localparam logic [STEP_W-1:0]     STEP_RESET  = 16'd655;
  localparam logic [FLOOR_W-1:0]    FLOOR_RESET = 16'd11;
  localparam logic [TAPS_CFG_W-1:0] TAPS_RESET  = 7'd64;
  localparam int                    MIN_TAPS    = 2;

  localparam sample_t SAMPLE_MAX = 16'sh7FFF;
  localparam sample_t SAMPLE_MIN = 16'sh8000;

endpackage
`default_nettype wire

@@ rtl/core/filtered_x_lms_adaptive_fir.sv @@
// Filtered-x LMS / NLMS adaptive FIR filter with one shared multiplier and sequencer.
// Depends on fxlms_pkg for widths, register codes and reset values.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in      | input     | in_valid / in_ready  | target_sample, ref_sample
//  out     | output    | out_valid / out_ready| filter_out, error_out, saturated
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Each sample makes two sweeps over the active taps through the shared multiplier, one
// tap per cycle; NLMS mode adds a 32-step restoring divide for the normalized step. A
// taps_in_use write rescans the active window to rebuild the energy sum.
// After reset a clearing pass zeroes both memories; no sample is taken then.
// The result waits in an output register, so the next sample is taken while it stalls.
`default_nettype none
module filtered_x_lms_adaptive_fir #(
  parameter int TAPS        = 64,
  parameter int WEIGHT_BITS = 24
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire  fxlms_pkg::sample_t            target_sample,
  input  wire  fxlms_pkg::sample_t            ref_sample,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output fxlms_pkg::sample_t                  filter_out,
  output fxlms_pkg::sample_t                  error_out,
  output logic                                saturated,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  fxlms_pkg::cfg_index_t         cfg_index,
  input  wire  [fxlms_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int IDX_W   = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int CNT_W   = $clog2(TAPS + 1);
  localparam int CMP_W   = (CNT_W > fxlms_pkg::TAPS_CFG_W) ? CNT_W : fxlms_pkg::TAPS_CFG_W;
  localparam int WFRAC   = WEIGHT_BITS - 2;
  localparam int ACC_W   = WEIGHT_BITS + fxlms_pkg::SAMPLE_W + $clog2(TAPS);
  localparam int SH      = fxlms_pkg::DELTA_FRAC - WFRAC;
  localparam int DLT_W   = fxlms_pkg::PROD_W - SH;
  localparam int SW      = fxlms_pkg::SAMPLE_W;
  localparam int MU_W    = fxlms_pkg::MU_W;
  localparam int DEN_W   = fxlms_pkg::DEN_W;
  localparam int DCNT_W  = $clog2(MU_W);

  localparam logic signed [ACC_W:0] Y_HALF = (ACC_W+1)'(1) << (WFRAC - 1);
  localparam logic signed [fxlms_pkg::PROD_W-1:0] D_HALF =
    fxlms_pkg::PROD_W'(1) << (SH - 1);
  localparam logic signed [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
  localparam logic signed [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

  // Sequencer states
  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_OLD    = 4'd2;
  localparam logic [3:0] S_NEWSQ  = 4'd3;
  localparam logic [3:0] S_NEWADD = 4'd4;
  localparam logic [3:0] S_DOT    = 4'd5;
  localparam logic [3:0] S_YOUT   = 4'd6;
  localparam logic [3:0] S_ERR    = 4'd7;
  localparam logic [3:0] S_DIV    = 4'd8;
  localparam logic [3:0] S_GAIN   = 4'd9;
  localparam logic [3:0] S_GLOAD  = 4'd10;
  localparam logic [3:0] S_UPD    = 4'd11;
  localparam logic [3:0] S_OUT    = 4'd12;
  localparam logic [3:0] S_RECALC = 4'd13;

  logic [3:0] state, state_next;

  // Configuration registers
  logic                               normalized_mode;
  logic [fxlms_pkg::STEP_W-1:0]       adapt_step;
  logic [fxlms_pkg::FLOOR_W-1:0]      norm_floor;
  logic [fxlms_pkg::TAPS_CFG_W-1:0]   taps_in_use;

  // Persistent state
  logic [IDX_W-1:0]                   ring_head;
  logic [fxlms_pkg::ENERGY_W-1:0]     energy_sum;

  // Memories
  fxlms_pkg::sample_t                 delay_mem [TAPS];
  logic signed [WEIGHT_BITS-1:0]      weight_mem [TAPS];
  fxlms_pkg::sample_t                 d_rdata;
  logic signed [WEIGHT_BITS-1:0]      w_rdata;
  logic                               d_wen, w_wen;
  logic [IDX_W-1:0]                   d_waddr, d_raddr, w_waddr, w_raddr;
  fxlms_pkg::sample_t                 d_wdata;
  logic signed [WEIGHT_BITS-1:0]      w_wdata;

  // Per-sample working registers
  fxlms_pkg::sample_t                 target_r, xnew_r, y_r, err_r;
  logic [IDX_W-1:0]                   head_r;
  logic                               sat_r;
  logic signed [ACC_W-1:0]            acc;
  logic [DEN_W-1:0]                   den_r, div_rem;
  logic [MU_W-1:0]                    div_num, mu_r;
  logic [DCNT_W-1:0]                  div_cnt;
  logic signed [fxlms_pkg::MUL_A_W-1:0] g_r;

  // Sweep pipeline
  logic [CNT_W-1:0]                   iss_k;
  logic [IDX_W-1:0]                   ptr, ptr_inc;
  logic                               rd_v, mul_v, dl_v;
  logic [IDX_W-1:0]                   rd_k, mul_k, dl_k;
  logic signed [WEIGHT_BITS-1:0]      w_mul, w_dl;
  logic signed [DLT_W-1:0]            dlt;

  // Shared multiplier
  logic signed [fxlms_pkg::MUL_A_W-1:0] mul_a;
  fxlms_pkg::sample_t                 mul_b;
  logic signed [fxlms_pkg::PROD_W-1:0] prod;

  // Combinational helpers
  logic [CMP_W-1:0]                   taps_x;
  logic [CNT_W-1:0]                   n_act;
  logic [IDX_W-1:0]                   head_idle, leave_idx;
  logic [CNT_W:0]                     leave_sum;
  logic                               in_fire, cfg_fire, out_free;
  logic                               sweep, issuing, sweep_done;
  logic signed [ACC_W:0]              acc_rnd, y_sh;
  logic                               y_ovf;
  logic signed [SW:0]                 e_wide;
  logic                               e_ovf;
  logic [DEN_W-1:0]                   den;
  logic                               mu_cap;
  logic [DEN_W:0]                     trial;
  logic                               trial_ge;
  logic signed [fxlms_pkg::PROD_W-1:0] d_rnd, d_sh;
  logic signed [DLT_W:0]              w_sum;
  logic                               w_ovf;
  logic signed [WEIGHT_BITS-1:0]      w_new;

  // Clamp the tap count to the supported window
  always_comb begin
    taps_x = CMP_W'(taps_in_use);
    if (taps_x < CMP_W'(fxlms_pkg::MIN_TAPS)) begin
      n_act = CNT_W'(fxlms_pkg::MIN_TAPS);
    end else if (taps_x > CMP_W'(TAPS)) begin
      n_act = CNT_W'(TAPS);
    end else begin
      n_act = CNT_W'(taps_x);
    end
  end

  // Ring positions: new head and the sample leaving the window
  assign head_idle = (ring_head == '0) ? IDX_W'(TAPS - 1) : ring_head - 1'b1;
  assign leave_sum = (CNT_W+1)'(head_idle) + (CNT_W+1)'(n_act);
  assign leave_idx = (leave_sum >= (CNT_W+1)'(TAPS)) ?
                     IDX_W'(leave_sum - (CNT_W+1)'(TAPS)) : IDX_W'(leave_sum);
  assign ptr_inc   = (ptr == IDX_W'(TAPS - 1)) ? '0 : ptr + 1'b1;

  // Handshakes
  assign cfg_ready = (state == S_IDLE) || (state == S_CLEAR);
  assign in_ready  = (state == S_IDLE) && !cfg_valid;
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_free  = !out_valid || out_ready;

  // Sweep control
  assign sweep      = (state == S_DOT) || (state == S_UPD) || (state == S_RECALC);
  assign issuing    = (iss_k != n_act);
  assign sweep_done = !issuing && !rd_v && !mul_v && !dl_v;

  // Output rounding and clipping
  assign acc_rnd = {acc[ACC_W-1], acc} + Y_HALF;
  assign y_sh    = acc_rnd >>> WFRAC;
  assign y_ovf   = !((&y_sh[ACC_W:SW-1]) || !(|y_sh[ACC_W:SW-1]));
  assign e_wide  = {target_r[SW-1], target_r} - {y_r[SW-1], y_r};
  assign e_ovf   = e_wide[SW] ^ e_wide[SW-1];

  // Normalization denominator and cap test
  assign den    = DEN_W'(norm_floor) + DEN_W'(energy_sum);
  assign mu_cap = DEN_W'(adapt_step[fxlms_pkg::STEP_W-1:2]) >= den;

  // One restoring divide step
  assign trial    = {div_rem, div_num[MU_W-1]};
  assign trial_ge = trial >= (DEN_W+1)'(den_r);

  // Weight delta rounding and saturating add
  assign d_rnd = prod + D_HALF;
  assign d_sh  = d_rnd >>> SH;
  assign w_sum = (DLT_W+1)'(w_dl) + (DLT_W+1)'(dlt);
  assign w_ovf = !((&w_sum[DLT_W:WEIGHT_BITS-1]) || !(|w_sum[DLT_W:WEIGHT_BITS-1]));
  assign w_new = w_ovf ? (w_sum[DLT_W] ? W_MIN : W_MAX) : w_sum[WEIGHT_BITS-1:0];

  // Select multiplier operands per phase
  always_comb begin
    mul_a = fxlms_pkg::MUL_A_W'(d_rdata);
    mul_b = d_rdata;
    case (state)
      S_NEWSQ: begin
        mul_a = fxlms_pkg::MUL_A_W'(xnew_r);
        mul_b = xnew_r;
      end
      S_DOT: begin
        mul_a = fxlms_pkg::MUL_A_W'(w_rdata);
        mul_b = d_rdata;
      end
      S_GAIN: begin
        mul_a = $signed({{(fxlms_pkg::MUL_A_W-MU_W){1'b0}}, mu_r});
        mul_b = err_r;
      end
      S_UPD: begin
        mul_a = g_r;
        mul_b = d_rdata;
      end
      default: begin
        mul_a = fxlms_pkg::MUL_A_W'(d_rdata);
        mul_b = d_rdata;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Memory port selection
  always_comb begin
    d_wen   = (state == S_CLEAR) || (state == S_OLD);
    d_waddr = (state == S_CLEAR) ? ptr : head_r;
    d_wdata = (state == S_CLEAR) ? '0 : xnew_r;
    d_raddr = (state == S_IDLE) ? leave_idx : ptr;
    w_wen   = (state == S_CLEAR) || ((state == S_UPD) && dl_v);
    w_waddr = (state == S_CLEAR) ? ptr : dl_k;
    w_wdata = (state == S_CLEAR) ? '0 : w_new;
    w_raddr = iss_k[IDX_W-1:0];
  end

  // Delay line memory
  always_ff @(posedge clk) begin
    if (d_wen) begin
      delay_mem[d_waddr] <= d_wdata;
    end
    d_rdata <= delay_mem[d_raddr];
  end

  // Weight memory
  always_ff @(posedge clk) begin
    if (w_wen) begin
      weight_mem[w_waddr] <= w_wdata;
    end
    w_rdata <= weight_mem[w_raddr];
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (ptr == IDX_W'(TAPS - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (cfg_fire && (cfg_index == fxlms_pkg::CFG_TAPS)) begin
          state_next = S_RECALC;
        end else if (in_fire) begin
          state_next = S_OLD;
        end
      end
      S_OLD:    state_next = S_NEWSQ;
      S_NEWSQ:  state_next = S_NEWADD;
      S_NEWADD: state_next = S_DOT;
      S_DOT:    if (sweep_done) state_next = S_YOUT;
      S_YOUT:   state_next = S_ERR;
      S_ERR:    state_next = (normalized_mode && !mu_cap) ? S_DIV : S_GAIN;
      S_DIV:    if (div_cnt == DCNT_W'(MU_W - 1)) state_next = S_GAIN;
      S_GAIN:   state_next = S_GLOAD;
      S_GLOAD:  state_next = S_UPD;
      S_UPD:    if (sweep_done) state_next = S_OUT;
      S_OUT:    if (out_free) state_next = S_IDLE;
      S_RECALC: if (sweep_done) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      ptr             <= '0;
      iss_k           <= '0;
      rd_v            <= 1'b0;
      mul_v           <= 1'b0;
      dl_v            <= 1'b0;
      out_valid       <= 1'b0;
      ring_head       <= '0;
      energy_sum      <= '0;
      normalized_mode <= 1'b0;
      adapt_step      <= fxlms_pkg::STEP_RESET;
      norm_floor      <= fxlms_pkg::FLOOR_RESET;
      taps_in_use     <= fxlms_pkg::TAPS_RESET;
    end else begin
      state <= state_next;
      rd_v  <= sweep && issuing;
      mul_v <= rd_v;
      dl_v  <= mul_v && (state == S_UPD);

      // Raise the result when it loads, drop it once the transfer completes
      if ((state == S_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      // Register writes
      if (cfg_fire) begin
        unique case (cfg_index)
          fxlms_pkg::CFG_MODE:  normalized_mode <= cfg_data[0];
          fxlms_pkg::CFG_STEP:  adapt_step <= cfg_data[fxlms_pkg::STEP_W-1:0];
          fxlms_pkg::CFG_FLOOR: norm_floor <= cfg_data[fxlms_pkg::FLOOR_W-1:0];
          fxlms_pkg::CFG_TAPS:  taps_in_use <= cfg_data[fxlms_pkg::TAPS_CFG_W-1:0];
          default: ;
        endcase
      end

      // Advance the sweep issue pointer
      if (sweep && issuing) begin
        iss_k <= iss_k + 1'b1;
        ptr   <= ptr_inc;
      end

      unique case (state)
        S_CLEAR: ptr <= ptr_inc;
        S_IDLE: begin
          if (cfg_fire && (cfg_index == fxlms_pkg::CFG_TAPS)) begin
            iss_k      <= '0;
            ptr        <= ring_head;
            energy_sum <= '0;
          end
        end
        S_OLD: ring_head <= head_r;
        S_NEWSQ: energy_sum <= energy_sum - prod[fxlms_pkg::ENERGY_W-1:0];
        S_NEWADD: begin
          energy_sum <= energy_sum + prod[fxlms_pkg::ENERGY_W-1:0];
          iss_k      <= '0;
          ptr        <= head_r;
        end
        S_GLOAD: begin
          iss_k <= '0;
          ptr   <= head_r;
        end
        S_RECALC: begin
          if (mul_v) begin
            energy_sum <= energy_sum + prod[fxlms_pkg::ENERGY_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    // Carry tap index and old weight down the sweep pipeline
    if (sweep && issuing) begin
      rd_k <= iss_k[IDX_W-1:0];
    end
    mul_k <= rd_k;
    dl_k  <= mul_k;
    w_mul <= w_rdata;
    w_dl  <= w_mul;
    dlt   <= d_sh[DLT_W-1:0];

    case (state)
      S_IDLE: begin
        if (in_fire) begin
          target_r <= target_sample;
          xnew_r   <= ref_sample;
          head_r   <= head_idle;
          sat_r    <= 1'b0;
        end
      end
      S_NEWADD: acc <= '0;
      S_DOT: begin
        if (mul_v) begin
          acc <= acc + prod[ACC_W-1:0];
        end
      end
      S_YOUT: begin
        y_r   <= y_ovf ? (y_sh[ACC_W] ? fxlms_pkg::SAMPLE_MIN : fxlms_pkg::SAMPLE_MAX)
                       : y_sh[SW-1:0];
        sat_r <= sat_r | y_ovf;
      end
      S_ERR: begin
        err_r   <= e_ovf ? (e_wide[SW] ? fxlms_pkg::SAMPLE_MIN : fxlms_pkg::SAMPLE_MAX)
                         : e_wide[SW-1:0];
        sat_r   <= sat_r | e_ovf;
        den_r   <= den;
        div_rem <= DEN_W'(adapt_step[fxlms_pkg::STEP_W-1:2]);
        div_num <= {adapt_step[1:0], {(MU_W-2){1'b0}}};
        div_cnt <= '0;
        if (!normalized_mode) begin
          mu_r <= MU_W'(adapt_step);
        end else if (mu_cap) begin
          mu_r <= '1;
        end else begin
          mu_r <= '0;
        end
      end
      S_DIV: begin
        div_rem <= trial_ge ? DEN_W'(trial - (DEN_W+1)'(den_r)) : DEN_W'(trial);
        div_num <= div_num << 1;
        mu_r    <= {mu_r[MU_W-2:0], trial_ge};
        div_cnt <= div_cnt + 1'b1;
      end
      S_GLOAD: g_r <= prod[fxlms_pkg::MUL_A_W-1:0];
      S_UPD: begin
        if (dl_v) begin
          sat_r <= sat_r | w_ovf;
        end
      end
      S_OUT: begin
        if (out_free) begin
          filter_out <= y_r;
          error_out  <= err_r;
          saturated  <= sat_r;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ bench/tb_filtered_x_lms_adaptive_fir.sv @@
// Self-checking bench for the filtered-x LMS/NLMS adaptive FIR filter.
// Depends on fxlms_pkg and filtered_x_lms_adaptive_fir; a scoreboard class tracks the
// delay line, weights and energy sum and checks every output transfer in order.
module tb_filtered_x_lms_adaptive_fir;
  import fxlms_pkg::*;

  localparam int TAPS           = 64;
  localparam int WEIGHT_BITS    = 24;
  localparam int WFRAC          = WEIGHT_BITS - 2;
  localparam int IDLE_PCT       = 37;
  localparam int RANDOM_ITEMS   = 1650;
  localparam int HOLDOFF_CYCLES = 600;
  localparam int QUIET_LIMIT    = 4000;
  localparam int END_DRAIN      = 300;
  localparam int REPORT_MAX     = 10;

  // Index outside the register map; writes to it must be dropped
  localparam cfg_index_t CFG_SPARE = 3'd6;

  localparam logic [63:0] MU_CAP = 64'hFFFF_FFFF;

  typedef struct packed {
    sample_t filt;
    sample_t err;
    logic    sat;
  } fir_result_t;

  // Tracks filter state and holds the results still owed by the block
  class adaptive_fir_scoreboard;
    sample_t                       line_x [TAPS];
    logic signed [WEIGHT_BITS-1:0] coef [TAPS];
    int unsigned                   newest;
    logic [ENERGY_W-1:0]           energy;
    logic                          nlms;
    logic [STEP_W-1:0]             step;
    logic [FLOOR_W-1:0]            floor_q;
    logic [TAPS_CFG_W-1:0]         taps_cfg;
    fir_result_t                   owed_results [$];
    int                            mismatches;
    bit                            clipped;

    function new();
      foreach (line_x[k]) begin
        line_x[k] = '0;
        coef[k]   = '0;
      end
      newest     = 0;
      energy     = '0;
      nlms       = 1'b0;
      step       = STEP_RESET;
      floor_q    = FLOOR_RESET;
      taps_cfg   = TAPS_RESET;
      mismatches = 0;
      clipped    = 1'b0;
    endfunction

    function int unsigned active_taps();
      if (taps_cfg < MIN_TAPS) return MIN_TAPS;
      if (taps_cfg > TAPS) return TAPS;
      return taps_cfg;
    endfunction

    // Sum of squares over the active window, wrapped to the energy width
    function logic [ENERGY_W-1:0] window_energy();
      longint sum;
      sum = 0;
      for (int unsigned k = 0; k < active_taps(); k++)
        sum += longint'(line_x[(newest + k) % TAPS]) * line_x[(newest + k) % TAPS];
      return ENERGY_W'(sum);
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      if (v < lo) begin
        clipped = 1'b1;
        return lo;
      end
      if (v > hi) begin
        clipped = 1'b1;
        return hi;
      end
      return v;
    endfunction

    function void apply_setting(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MODE:  nlms = data[0];
        CFG_STEP:  step = data;
        CFG_FLOOR: floor_q = data;
        CFG_TAPS: begin
          taps_cfg = data[TAPS_CFG_W-1:0];
          energy   = window_energy();
        end
        default: ;
      endcase
    endfunction

    // Shift in one sample, filter, adapt, and queue the result it owes
    function void take_sample(sample_t tgt, sample_t xin);
      int unsigned   n;
      int unsigned   leave;
      longint        xold;
      longint        acc;
      longint        y;
      longint        e;
      longint        g;
      longint        d;
      longint        w;
      logic [63:0]   den;
      logic [63:0]   mu;
      fir_result_t   res;
      n       = active_taps();
      newest  = (newest == 0) ? TAPS - 1 : newest - 1;
      leave   = (newest + n) % TAPS;
      xold    = line_x[leave];
      clipped = 1'b0;
      line_x[newest] = xin;
      energy = energy + ENERGY_W'(longint'(xin) * xin) - ENERGY_W'(xold * xold);

      acc = 0;
      for (int unsigned k = 0; k < n; k++)
        acc += longint'(coef[k]) * line_x[(newest + k) % TAPS];
      y = clip((acc + (longint'(1) << (WFRAC - 1))) >>> WFRAC, SAMPLE_MIN, SAMPLE_MAX);
      e = clip(longint'(tgt) - y, SAMPLE_MIN, SAMPLE_MAX);

      if (nlms) begin
        den = 64'(floor_q) + 64'(energy);
        if (den == 0) begin
          mu = MU_CAP;
        end else begin
          mu = (64'(step) << 30) / den;
          if (mu > MU_CAP) mu = MU_CAP;
        end
      end else begin
        mu = 64'(step);
      end

      // Update only the active weights; the rest hold
      g = longint'(mu) * e;
      for (int unsigned k = 0; k < n; k++) begin
        d = (g * line_x[(newest + k) % TAPS] + (longint'(1) << (DELTA_FRAC - WFRAC - 1)))
            >>> (DELTA_FRAC - WFRAC);
        w = clip(longint'(coef[k]) + d, -(longint'(1) << (WEIGHT_BITS - 1)),
                 (longint'(1) << (WEIGHT_BITS - 1)) - 1);
        coef[k] = w[WEIGHT_BITS-1:0];
      end

      res.filt = y[SAMPLE_W-1:0];
      res.err  = e[SAMPLE_W-1:0];
      res.sat  = clipped;
      owed_results.push_back(res);
    endfunction

    function void check_result(sample_t filt, sample_t err, logic sat);
      fir_result_t exp_res;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected output transfer: y=%0d err=%0d sat=%0b", filt, err, sat);
        return;
      end
      exp_res = owed_results.pop_front();
      if (filt !== exp_res.filt || err !== exp_res.err || sat !== exp_res.sat) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("output mismatch: expected y=%0d err=%0d sat=%0b, got y=%0d err=%0d sat=%0b",
                   exp_res.filt, exp_res.err, exp_res.sat, filt, err, sat);
      end
    endfunction

    function int unsigned outstanding();
      return owed_results.size();
    endfunction

    function int failures();
      return mismatches + owed_results.size();
    endfunction
  endclass

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  in_valid      = 1'b0;
  sample_t               target_sample = '0;
  sample_t               ref_sample    = '0;
  logic                  out_ready     = 1'b0;
  logic                  cfg_valid     = 1'b0;
  cfg_index_t            cfg_index     = CFG_MODE;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;
  logic                  in_ready;
  logic                  out_valid;
  logic                  cfg_ready;
  sample_t               filter_out;
  sample_t               error_out;
  logic                  saturated;

  bit                     no_idle      = 1'b0;
  bit                     holdoff_req  = 1'b0;
  int                     holdoff_left = 0;
  int                     quiet        = 0;
  adaptive_fir_scoreboard sb;

  filtered_x_lms_adaptive_fir #(
    .TAPS        (TAPS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .target_sample (target_sample),
    .ref_sample    (ref_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .filter_out    (filter_out),
    .error_out     (error_out),
    .saturated     (saturated),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: random stalls, a quiet stretch, and one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ready = 1'b0;
      end else if (holdoff_req) begin
        holdoff_req  = 1'b0;
        holdoff_left = HOLDOFF_CYCLES;
        out_ready    = 1'b0;
      end else begin
        out_ready = no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Observe every transfer at the rising edge; watch for a stuck block
  always @(posedge clk) begin
    if (!rst && sb != null) begin
      if (cfg_valid && cfg_ready) sb.apply_setting(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.take_sample(target_sample, ref_sample);
      if (out_valid && out_ready) sb.check_result(filter_out, error_out, saturated);
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Offer one sample and hold it until the transfer; returns at a falling edge
  task automatic send_sample(input sample_t tgt, input sample_t xin);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    target_sample = tgt;
    ref_sample    = xin;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Keep cfg_valid high across back-to-back writes; caller drops it afterwards
  task automatic write_setting(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Drop the input and wait for every owed result
  task automatic wait_idle();
    in_valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  task automatic shuffle_settings();
    int unsigned pick;
    if ($urandom_range(1)) write_setting(CFG_MODE, CFG_DATA_W'($urandom));
    if ($urandom_range(1)) begin
      pick = $urandom_range(99);
      write_setting(CFG_STEP, pick < 10 ? '0 : pick < 20 ? '1 :
                    pick < 70 ? CFG_DATA_W'($urandom_range(1, 2048)) : CFG_DATA_W'($urandom));
    end
    if ($urandom_range(1)) begin
      pick = $urandom_range(99);
      write_setting(CFG_FLOOR, pick < 15 ? '0 : pick < 25 ? '1 : CFG_DATA_W'($urandom));
    end
    // Mostly short windows to keep the run quick, with full and out-of-range counts too
    if ($urandom_range(2) != 0) begin
      pick = $urandom_range(99);
      pick = pick < 50 ? $urandom_range(MIN_TAPS, 12) :
             pick < 70 ? $urandom_range(13, TAPS - 1) :
             pick < 85 ? TAPS :
             pick < 93 ? $urandom_range(MIN_TAPS - 1) :
                         $urandom_range(TAPS + 1, 2 ** TAPS_CFG_W - 1);
      write_setting(CFG_TAPS, {(CFG_DATA_W - TAPS_CFG_W)'($urandom), TAPS_CFG_W'(pick)});
    end
    if ($urandom_range(19) == 0)
      write_setting(cfg_index_t'($urandom_range(CFG_TAPS + 1, 2 ** CFG_IDX_W - 1)),
                    CFG_DATA_W'($urandom));
    cfg_valid = 1'b0;
  endtask

  function automatic sample_t pick_sample();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 10) return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
    if (sel < 45) return sample_t'(int'($urandom_range(2048)) - 1024);
    return sample_t'($urandom);
  endfunction

  initial begin
    int unsigned phase;
    int unsigned in_phase;
    int unsigned sent;
    bit          tracking;
    sample_t     prev_ref;
    sample_t     xin;
    sample_t     tgt;
    sb = new();
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Zero denominator: NLMS, no floor, empty delay line
    write_setting(CFG_MODE, 16'd1);
    write_setting(CFG_FLOOR, '0);
    cfg_valid = 1'b0;
    send_sample(SAMPLE_MAX, '0);
    send_sample(SAMPLE_MIN, '0);
    // Tiny energy pushes mu to its cap and the weights into the rails
    send_sample(SAMPLE_MAX, 16'sd1);
    send_sample(SAMPLE_MIN, SAMPLE_MAX);
    send_sample(SAMPLE_MAX, SAMPLE_MIN);
    send_sample('0, '0);
    wait_idle();

    // Plain LMS at full step, tap count below range
    write_setting(CFG_MODE, '0);
    write_setting(CFG_STEP, '1);
    write_setting(CFG_TAPS, '0);
    cfg_valid = 1'b0;
    send_sample(SAMPLE_MAX, SAMPLE_MAX);
    send_sample(SAMPLE_MIN, SAMPLE_MIN);
    send_sample(SAMPLE_MAX, SAMPLE_MIN);
    send_sample(SAMPLE_MIN, SAMPLE_MAX);
    send_sample('0, '0);
    send_sample(16'sd1, -16'sd1);
    wait_idle();

    // Tap count above range, zero step, top floor, write to an unmapped index
    write_setting(CFG_TAPS, 16'h007F);
    write_setting(CFG_STEP, '0);
    write_setting(CFG_FLOOR, '1);
    write_setting(CFG_SPARE, '1);
    cfg_valid = 1'b0;
    send_sample(SAMPLE_MAX, SAMPLE_MIN);
    send_sample(SAMPLE_MIN, SAMPLE_MAX);
    send_sample(-16'sd1, 16'sd1);
    wait_idle();

    // NLMS with a tap count of one, clamped to the shortest legal window
    write_setting(CFG_MODE, 16'd1);
    write_setting(CFG_STEP, '1);
    write_setting(CFG_TAPS, 16'd1);
    cfg_valid = 1'b0;
    send_sample(SAMPLE_MAX, SAMPLE_MAX);
    send_sample(SAMPLE_MIN, -16'sd1);

    // Random phases, each under fresh settings
    sent     = 0;
    phase    = 0;
    prev_ref = '0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      no_idle = (phase >= 4 && phase < 8);
      if (phase == 5) holdoff_req = 1'b1;
      shuffle_settings();
      in_phase = $urandom_range(30, 90);
      tracking = $urandom_range(1);
      repeat (in_phase) begin
        xin = pick_sample();
        // Target follows a scaled copy of the reference so the weights can converge
        if (tracking && $urandom_range(3) != 0)
          tgt = sample_t'(int'(prev_ref) / 2 + int'($urandom_range(64)) - 32);
        else
          tgt = pick_sample();
        send_sample(tgt, xin);
        prev_ref = xin;
        sent++;
      end
      phase++;
    end

    wait_idle();
    repeat (END_DRAIN) @(negedge clk);
    if (sb.failures() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/fxlms_pkg.sv
rtl/core/filtered_x_lms_adaptive_fir.sv
bench/tb_filtered_x_lms_adaptive_fir.sv
